>>> design/cpd_pkg.sv
// shared types, register indexes and crc helpers for the packet deframer
// no dependencies; used by cpd_handler_lookup and crc_checked_packet_deframer_top
package cpd_pkg;

    localparam int HANDLER_SLOTS = 4;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_OVERSIZE = 2'd2
    } kind_t;

    localparam logic [2:0] REG_MAX_PAYLOAD_LEN = 3'd0;
    localparam logic [2:0] REG_HANDLER_COUNT   = 3'd1;
    localparam logic [2:0] REG_HANDLER_TYPE_0  = 3'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    typedef struct packed {
        logic       hit;
        logic [1:0] slot;
    } match_t;

    // crc-16-ccitt, poly 0x1021, one byte, msb first
    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] data);
        logic [7:0] x;
        x = crc[15:8] ^ data;
        x = x ^ (x >> 4);
        return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000}
               ^ {8'h00, x};
    endfunction

    function automatic logic [15:0] crc_header(input logic [31:0] hdr);
        logic [15:0] crc;
        crc = CRC_INIT;
        crc = crc_add(crc, hdr[31:24]);
        crc = crc_add(crc, hdr[23:16]);
        crc = crc_add(crc, hdr[15:8]);
        crc = crc_add(crc, hdr[7:0]);
        return crc;
    endfunction

endpackage

>>> design/cpd_handler_lookup.sv
// configuration registers and handler type table lookup
// depends on cpd_pkg
module cpd_handler_lookup (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic [15:0]         lookup_type,
    output logic [15:0]         max_payload_len,
    output cpd_pkg::match_t     match
);

    logic [15:0] max_len_reg;
    logic [2:0]  count_reg;
    logic [15:0] type_reg [cpd_pkg::HANDLER_SLOTS];
    logic [2:0]  active_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= 16'hFFFF;
            count_reg   <= 3'd0;
            for (int i = 0; i < cpd_pkg::HANDLER_SLOTS; i++)
            begin
                type_reg[i] <= 16'h0000;
            end
        end
        else if (cfg_write)
        begin
            if (cfg_index == cpd_pkg::REG_MAX_PAYLOAD_LEN)
            begin
                max_len_reg <= cfg_data;
            end
            if (cfg_index == cpd_pkg::REG_HANDLER_COUNT)
            begin
                count_reg <= cfg_data[2:0];
            end
            for (int i = 0; i < cpd_pkg::HANDLER_SLOTS; i++)
            begin
                if (cfg_index == cpd_pkg::REG_HANDLER_TYPE_0 + 3'(i))
                begin
                    type_reg[i] <= cfg_data;
                end
            end
        end
    end

    assign active_count = (count_reg > 3'(cpd_pkg::HANDLER_SLOTS))
                        ? 3'(cpd_pkg::HANDLER_SLOTS) : count_reg;

    always_comb
    begin
        match.hit  = 1'b0;
        match.slot = 2'd0;
        for (int i = 0; i < cpd_pkg::HANDLER_SLOTS; i++)
        begin
            if (!match.hit && (3'(i) < active_count) && (type_reg[i] == lookup_type))
            begin
                match.hit  = 1'b1;
                match.slot = 2'(i);
            end
        end
    end

    assign max_payload_len = max_len_reg;

endmodule

>>> design/crc_checked_packet_deframer_top.sv
// crc-checked packet deframer: one byte per transfer in, at most one result per byte out
// a result is captured in the output register on the transfer of its byte
// throughput: one byte per cycle while the output drains; header crc and handler match are combinational
// the next byte is taken while a result waits, as long as the output register drains
// reset: async low; idle, window and count zero, no result, max_payload_len 65535, handlers 0
// depends on cpd_pkg and cpd_handler_lookup
module crc_checked_packet_deframer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  payload_byte,
    output logic [15:0] byte_offset,
    output logic [15:0] packet_type,
    output logic        last,
    output logic        handler_hit,
    output logic [1:0]  handler_slot
);

    logic [47:0] window_reg, window_next;
    logic        receiving_reg, receiving_next;
    logic [15:0] count_reg, count_next;

    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  payload_reg;
    logic [15:0] offset_reg;
    logic [15:0] type_reg;
    logic        last_reg;
    logic        hit_reg;
    logic [1:0]  slot_reg;

    logic        in_fire;
    logic        emit;
    logic [1:0]  emit_kind;
    logic [7:0]  emit_byte;
    logic [15:0] emit_offset;
    logic        emit_last;
    logic [15:0] hdr_size;
    logic [15:0] max_payload_len;
    logic [16:0] count_inc;
    logic [15:0] stored_crc;
    cpd_pkg::match_t match;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    cpd_handler_lookup u_lookup (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .lookup_type     (window_next[47:32]),
        .max_payload_len (max_payload_len),
        .match           (match)
    );

    assign count_inc  = {1'b0, count_reg} + 17'd1;
    assign stored_crc = {window_next[7:0], window_next[15:8]};
    assign hdr_size   = window_next[31:16];

    always_comb
    begin
        window_next    = receiving_reg ? window_reg : {window_reg[39:0], in_byte};
        receiving_next = receiving_reg;
        count_next     = count_reg;
        emit           = 1'b0;
        emit_kind      = cpd_pkg::KIND_PAYLOAD;
        emit_byte      = 8'h00;
        emit_offset    = 16'h0000;
        emit_last      = 1'b1;
        if (!receiving_reg)
        begin
            if (cpd_pkg::crc_header(window_next[47:16]) == stored_crc)
            begin
                count_next = 16'h0000;
                if (hdr_size == 16'h0000)
                begin
                    emit      = 1'b1;
                    emit_kind = cpd_pkg::KIND_EMPTY;
                end
                else
                begin
                    receiving_next = 1'b1;
                end
            end
        end
        else if (hdr_size > max_payload_len)
        begin
            receiving_next = 1'b0;
            emit           = 1'b1;
            emit_kind      = cpd_pkg::KIND_OVERSIZE;
        end
        else
        begin
            emit        = 1'b1;
            emit_byte   = in_byte;
            emit_offset = count_reg;
            emit_last   = count_inc >= {1'b0, hdr_size};
            count_next  = count_inc[15:0];
            if (emit_last)
            begin
                receiving_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= 48'h0;
            receiving_reg <= 1'b0;
            count_reg     <= 16'h0000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                window_reg    <= window_next;
                receiving_reg <= receiving_next;
                count_reg     <= count_next;
                out_valid_reg <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            kind_reg    <= emit_kind;
            payload_reg <= emit_byte;
            offset_reg  <= emit_offset;
            type_reg    <= window_next[47:32];
            last_reg    <= emit_last;
            hit_reg     <= match.hit;
            slot_reg    <= match.slot;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign payload_byte = payload_reg;
    assign byte_offset  = offset_reg;
    assign packet_type  = type_reg;
    assign last         = last_reg;
    assign handler_hit  = hit_reg;
    assign handler_slot = slot_reg;

`ifndef SYNTHESIS
    // every byte taken while receiving yields a result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && receiving_reg |=> out_valid_reg)
        else $error("no result for byte taken while receiving");

    // empty and oversize results are final and carry no byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (kind_reg != cpd_pkg::KIND_PAYLOAD)
        |-> last_reg && (payload_reg == 8'h00) && (offset_reg == 16'h0000))
        else $error("non-payload result malformed");

    // a non-final payload byte leaves the deframer receiving
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (kind_reg == cpd_pkg::KIND_PAYLOAD) && !last_reg
        |-> receiving_reg)
        else $error("packet ended without last mark");

    // slot is zero whenever no handler matched
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !hit_reg |-> slot_reg == 2'd0)
        else $error("handler slot set without hit");
`endif

endmodule

>>> sim/tb_top.sv
// testbench for crc_checked_packet_deframer_top: builds crc-framed packets, noise and broken
// headers, predicts every result in its own deframer model and checks each output transfer
// depends on cpd_pkg and the deframer rtl
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        cpd_pkg::kind_t kind;
        logic [7:0]     data;
        logic [15:0]    offset;
        logic [15:0]    ptype;
        logic           last;
        logic           hit;
        logic [1:0]     slot;
    } frame_result_t;

    localparam logic [2:0] REG_UNUSED_6 =
        3'(cpd_pkg::REG_HANDLER_TYPE_0 + cpd_pkg::HANDLER_SLOTS);
    localparam logic [2:0] REG_UNUSED_7 = REG_UNUSED_6 + 3'd1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_offset;
    logic [15:0] packet_type;
    logic        last;
    logic        handler_hit;
    logic [1:0]  handler_slot;

    // deframer model state
    logic [47:0] hdr_win;
    logic        rx_busy;
    logic [15:0] rx_count;
    logic [15:0] cfg_max_len;
    logic [2:0]  cfg_handlers;
    logic [15:0] cfg_types [cpd_pkg::HANDLER_SLOTS];

    frame_result_t deframed_q[$];
    int          errors = 0;
    int          items_sent = 0;
    bit          in_idle_on = 1'b1;
    bit          out_idle_on = 1'b1;
    int          hold_request = 0;

    crc_checked_packet_deframer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .payload_byte (payload_byte),
        .byte_offset  (byte_offset),
        .packet_type  (packet_type),
        .last         (last),
        .handler_hit  (handler_hit),
        .handler_slot (handler_slot)
    );

    always #1 clk = ~clk;

    initial
    begin
        #400000;
        $display("FAIL crc_checked_packet_deframer_top");
        $finish;
    end

    // bitwise crc-16-ccitt, msb first, init all ones
    function automatic logic [15:0] header_crc(input logic [31:0] hdr);
        logic [15:0] crc;
        logic        fb;
        crc = 16'hFFFF;
        for (int i = 31; i >= 0; i--)
        begin
            fb = crc[15] ^ hdr[i];
            crc = {crc[14:0], 1'b0};
            if (fb)
                crc = crc ^ 16'h1021;
        end
        return crc;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40)
            $display("ERROR %0t: %s", $time, msg);
    endtask

    task automatic push_result(input cpd_pkg::kind_t k, input logic [7:0] d,
                               input logic [15:0] off, input logic l);
        frame_result_t r;
        int            n;
        r.kind = k;
        r.data = d;
        r.offset = off;
        r.ptype = hdr_win[47:32];
        r.last = l;
        r.hit = 1'b0;
        r.slot = '0;
        n = (cfg_handlers > cpd_pkg::HANDLER_SLOTS) ? cpd_pkg::HANDLER_SLOTS : cfg_handlers;
        for (int i = n - 1; i >= 0; i--)
        begin
            if (cfg_types[i] == r.ptype)
            begin
                r.hit = 1'b1;
                r.slot = i[1:0];
            end
        end
        deframed_q.push_back(r);
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic [16:0] next_count;
        logic        fin;
        if (!rx_busy)
        begin
            hdr_win = {hdr_win[39:0], b};
            if (header_crc(hdr_win[47:16]) == {hdr_win[7:0], hdr_win[15:8]})
            begin
                rx_count = '0;
                if (hdr_win[31:16] == 16'd0)
                    push_result(cpd_pkg::KIND_EMPTY, 8'd0, 16'd0, 1'b1);
                else
                    rx_busy = 1'b1;
            end
        end
        else if (hdr_win[31:16] > cfg_max_len)
        begin
            rx_busy = 1'b0;
            push_result(cpd_pkg::KIND_OVERSIZE, 8'd0, 16'd0, 1'b1);
        end
        else
        begin
            next_count = {1'b0, rx_count} + 17'd1;
            fin = (next_count >= {1'b0, hdr_win[31:16]});
            push_result(cpd_pkg::KIND_PAYLOAD, b, rx_count, fin);
            rx_count = next_count[15:0];
            if (fin)
                rx_busy = 1'b0;
        end
    endtask

    task automatic check_result();
        frame_result_t exp_r;
        if (deframed_q.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing expected: kind %0d byte %02h",
                                      kind, payload_byte));
        end
        else
        begin
            exp_r = deframed_q.pop_front();
            if (kind !== exp_r.kind || payload_byte !== exp_r.data
                || byte_offset !== exp_r.offset || packet_type !== exp_r.ptype
                || last !== exp_r.last || handler_hit !== exp_r.hit
                || handler_slot !== exp_r.slot)
            begin
                report_mismatch($sformatf(
                    "got k%0d b%h o%0d t%h l%b h%b s%0d, want k%0d b%h o%0d t%h l%b h%b s%0d",
                    kind, payload_byte, byte_offset, packet_type, last, handler_hit,
                    handler_slot, exp_r.kind, exp_r.data, exp_r.offset, exp_r.ptype,
                    exp_r.last, exp_r.hit, exp_r.slot));
            end
        end
    endtask

    // output side: checks each transfer, random stalls and long hold-offs
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                check_result();
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (out_idle_on && $urandom_range(0, 99) < 37)
                out_ready <= 1'b0;
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (in_idle_on && $urandom_range(0, 99) < 37)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        deframe_byte(b);
        items_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] d);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == cpd_pkg::REG_MAX_PAYLOAD_LEN)
            cfg_max_len = d;
        else if (idx == cpd_pkg::REG_HANDLER_COUNT)
            cfg_handlers = d[2:0];
        else if (idx >= cpd_pkg::REG_HANDLER_TYPE_0 && idx < REG_UNUSED_6)
            cfg_types[2'(idx - cpd_pkg::REG_HANDLER_TYPE_0)] = d;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (deframed_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // header, then size payload bytes, one byte if oversize; broken ones get a flipped bit and 0 to 3 bytes
    task automatic send_packet(input logic [15:0] ptype, input logic [15:0] size,
                               input bit corrupt);
        logic [7:0]  hdr [6];
        logic [15:0] crc;
        int          n;
        crc = header_crc({ptype, size});
        hdr[0] = ptype[15:8];
        hdr[1] = ptype[7:0];
        hdr[2] = size[15:8];
        hdr[3] = size[7:0];
        hdr[4] = crc[7:0];
        hdr[5] = crc[15:8];
        if (corrupt)
            hdr[3'($urandom_range(0, 5))] ^= 8'd1 << $urandom_range(0, 7);
        for (int i = 0; i < 6; i++)
            send_byte(hdr[i]);
        if (corrupt)
            n = $urandom_range(0, 3);
        else if (size > cfg_max_len)
            n = 1;
        else
            n = size;
        repeat (n) send_byte(8'($urandom_range(0, 255)));
    endtask

    function automatic logic [15:0] pick_type();
        case ($urandom_range(0, 5))
            0, 1, 2: return cfg_types[2'($urandom_range(0, cpd_pkg::HANDLER_SLOTS - 1))];
            3: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [15:0] pick_size();
        int top;
        top = ($urandom_range(0, 9) == 0) ? 48 : 12;
        if (cfg_max_len < top)
            top = cfg_max_len;
        return 16'($urandom_range(0, top));
    endfunction

    task automatic randomize_config();
        logic [15:0] t;
        case ($urandom_range(0, 5))
            0: write_reg(cpd_pkg::REG_MAX_PAYLOAD_LEN, 16'd0);
            1: write_reg(cpd_pkg::REG_MAX_PAYLOAD_LEN, 16'hFFFF);
            2, 3: write_reg(cpd_pkg::REG_MAX_PAYLOAD_LEN, 16'($urandom_range(0, 16)));
            default: write_reg(cpd_pkg::REG_MAX_PAYLOAD_LEN, 16'($urandom_range(0, 65535)));
        endcase
        if ($urandom_range(0, 3) == 0)
            write_reg(cpd_pkg::REG_HANDLER_COUNT, 16'($urandom_range(0, 65535)));
        else
            write_reg(cpd_pkg::REG_HANDLER_COUNT,
                      16'($urandom_range(0, cpd_pkg::HANDLER_SLOTS)));
        t = '0;
        for (int i = 0; i < cpd_pkg::HANDLER_SLOTS; i++)
        begin
            case ($urandom_range(0, 5))
                0: t = 16'h0000;
                1: t = 16'hFFFF;
                2: t = t;
                default: t = 16'($urandom_range(0, 65535));
            endcase
            write_reg(cpd_pkg::REG_HANDLER_TYPE_0 + 3'(i), t);
        end
    endtask

    task automatic test_defaults_after_reset();
        in_idle_on = 1'b1;
        out_idle_on = 1'b1;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_packet(16'h0000, 16'd0, 1'b0);
        wait_idle();
    endtask

    // handler count above the slot count, unused register indexes, one-byte packet,
    // oversize drop, and the window carrying the previous header
    task automatic test_special_cases();
        write_reg(cpd_pkg::REG_MAX_PAYLOAD_LEN, 16'd3);
        write_reg(cpd_pkg::REG_HANDLER_COUNT, 16'hFFFF);
        write_reg(cpd_pkg::REG_HANDLER_TYPE_0, 16'h1111);
        write_reg(cpd_pkg::REG_HANDLER_TYPE_0 + 3'd1, 16'h2222);
        write_reg(cpd_pkg::REG_HANDLER_TYPE_0 + 3'd2, 16'h3333);
        write_reg(cpd_pkg::REG_HANDLER_TYPE_0 + 3'd3, 16'hABCD);
        write_reg(REG_UNUSED_6, 16'h0000);
        write_reg(REG_UNUSED_7, 16'hFFFF);
        send_packet(16'hABCD, 16'd1, 1'b0);
        send_packet(16'h2222, 16'd4, 1'b0);
        wait_idle();
    endtask

    task automatic test_backpressure();
        write_reg(cpd_pkg::REG_MAX_PAYLOAD_LEN, 16'hFFFF);
        in_idle_on = 1'b0;
        out_idle_on = 1'b0;
        hold_request = 300;
        send_packet(pick_type(), 16'd40, 1'b0);
        wait_idle();
    endtask

    task automatic test_no_idle_stretch();
        in_idle_on = 1'b0;
        out_idle_on = 1'b0;
        randomize_config();
        repeat (10) send_packet(pick_type(), pick_size(), 1'b0);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int target;
        int sel;
        target = items_sent + 300;
        while (items_sent < target)
        begin
            in_idle_on = ($urandom_range(0, 7) != 0);
            out_idle_on = ($urandom_range(0, 7) != 0);
            randomize_config();
            repeat ($urandom_range(4, 10))
            begin
                sel = $urandom_range(0, 99);
                if (sel < 70 || (sel < 80 && cfg_max_len == 16'hFFFF))
                    send_packet(pick_type(), pick_size(), 1'b0);
                else if (sel < 80)
                    send_packet(pick_type(), 16'($urandom_range(cfg_max_len + 1, 65535)),
                                1'b0);
                else if (sel < 90)
                    send_packet(pick_type(), pick_size(), 1'b1);
                else
                    repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end
            wait_idle();
        end
    endtask

    initial
    begin
        hdr_win = '0;
        rx_busy = 1'b0;
        rx_count = '0;
        cfg_max_len = 16'hFFFF;
        cfg_handlers = '0;
        for (int i = 0; i < cpd_pkg::HANDLER_SLOTS; i++)
            cfg_types[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults_after_reset();
        test_special_cases();
        test_backpressure();
        test_no_idle_stretch();
        test_random_traffic();
        wait_idle();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("PASS crc_checked_packet_deframer_top");
        else
            $display("FAIL crc_checked_packet_deframer_top");
        $finish;
    end

endmodule
